// ===== hw/rtl/crsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc_pkg: shared definitions for the cell record stream checker
// Constants of the file layout, the FNV-1a-64 step, result word codes and the
// result record that travels from the parser to the output register.
// ----------------------------------------------------------------------------
package crsc_pkg;

  localparam logic [63:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;

  localparam int HeaderLen  = 4 * 5;
  localparam int RecordLen  = 8 + 4 * (3 + 4 + 3);
  localparam int TrailerLen = 8;

  localparam int POS_W = 40;
  localparam int OFF_W = 6;

  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HEADER_END  = POS_W'(HeaderLen);
  localparam logic [POS_W-1:0] FILE_END_0  = POS_W'(HeaderLen + TrailerLen);
  localparam logic [OFF_W-1:0] REC_LAST    = OFF_W'(RecordLen - 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b1;

  // Header word slots (byte position divided by four).
  localparam logic [2:0] HDR_MAGIC   = 3'd0;
  localparam logic [2:0] HDR_VERSION = 3'd1;
  localparam logic [2:0] HDR_X       = 3'd2;
  localparam logic [2:0] HDR_Y       = 3'd3;

  // Result word kinds.
  localparam logic [2:0] KIND_ID       = 3'd0;
  localparam logic [2:0] KIND_POSITION = 3'd1;
  localparam logic [2:0] KIND_ROTATION = 3'd2;
  localparam logic [2:0] KIND_SCALE    = 3'd3;
  localparam logic [2:0] KIND_STATUS   = 3'd4;

  typedef struct packed {
    logic [2:0]         word_kind;
    logic [1:0]         component;
    logic [31:0]        record_number;
    logic [63:0]        word_value;
    logic               verdict;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic [31:0]        records_declared;
    logic               end_of_file;
  } result_t;

  // One FNV-1a-64 step. The prime is 2^40 + 0x1b3, so the product is a sum of
  // seven shifted copies.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

  // Writes one byte into a byte lane of a 64-bit word.
  function automatic logic [63:0] put_lane(input logic [63:0] word, input logic [2:0] lane,
                                           input logic [7:0] b);
    logic [63:0] res;
    res = word;
    res[{lane, 3'b000} +: 8] = b;
    return res;
  endfunction

  // 20 + 48 * count, built from shifts.
  function automatic logic [POS_W-1:0] body_end_of(input logic [31:0] count);
    logic [POS_W-1:0] c;
    c = {{(POS_W-32){1'b0}}, count};
    return (c << 5) + (c << 4) + HEADER_END;
  endfunction

endpackage

// ===== hw/rtl/crsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc channel interfaces
// Byte request channel, result word channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface crsc_word_if;
  logic               valid;
  logic               ready;
  logic [2:0]         word_kind;
  logic [1:0]         component;
  logic [31:0]        record_number;
  logic [63:0]        word_value;
  logic               verdict;
  logic signed [31:0] cell_x;
  logic signed [31:0] cell_y;
  logic [31:0]        records_declared;
  logic               end_of_file;

  modport source (output valid, output word_kind, output component, output record_number,
                  output word_value, output verdict, output cell_x, output cell_y,
                  output records_declared, output end_of_file, input ready);
  modport sink   (input valid, input word_kind, input component, input record_number,
                  input word_value, input verdict, input cell_x, input cell_y,
                  input records_declared, input end_of_file, output ready);
endinterface

interface crsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [crsc_pkg::CFG_IDX_W-1:0] reg_index;
  logic [31:0]                   write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== hw/rtl/cell_record_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_record_stream_checker: record file parser with FNV-1a-64 check
//
//   channel  dir  payload                                     handshake
//   in_if    in   data_byte, final_byte                       valid/ready
//   out_if   out  record word or final status                 valid/ready
//   cfg_if   in   reg_index, write_data (magic, version)      valid/ready
//
// One byte is accepted per cycle unless a stalled result backs up the input
// register; an accepted byte is held in the input, then the output register.
// The rate is set by the hash step, one shift-and-add product per cycle.
// Reset is synchronous; it clears the file state and both config registers.
// A stalled result holds the output register; the input register still takes
// one more byte, then the input side waits.
// ----------------------------------------------------------------------------
module cell_record_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  crsc_byte_if.sink  in_if,
  crsc_word_if.source out_if,
  crsc_cfg_if.sink   cfg_if
);

  logic [31:0] magic_r;
  logic [31:0] version_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_final_r;

  logic              out_valid_r;
  crsc_pkg::result_t out_r;

  logic              out_free;
  logic              s1_go;
  logic              res_valid;
  crsc_pkg::result_t res;

  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_go       = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || s1_go;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        crsc_pkg::CFG_MAGIC:   magic_r   <= cfg_if.write_data;
        crsc_pkg::CFG_VERSION: version_r <= cfg_if.write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r  <= in_if.data_byte;
      s1_final_r <= in_if.final_byte;
    end
  end

  crsc_parse u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (s1_go),
    .data_byte        (s1_byte_r),
    .final_byte       (s1_final_r),
    .expected_magic   (magic_r),
    .expected_version (version_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.word_kind        = out_r.word_kind;
  assign out_if.component        = out_r.component;
  assign out_if.record_number    = out_r.record_number;
  assign out_if.word_value       = out_r.word_value;
  assign out_if.verdict          = out_r.verdict;
  assign out_if.cell_x           = out_r.cell_x;
  assign out_if.cell_y           = out_r.cell_y;
  assign out_if.records_declared = out_r.records_declared;
  assign out_if.end_of_file      = out_r.end_of_file;

`ifndef ASSERT_OFF
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && res_valid |=> out_valid_r)
    else $error("parser result did not reach the output register");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.end_of_file |->
      out_r.word_kind == crsc_pkg::KIND_STATUS && out_r.component == 2'd0)
    else $error("status item with a record word kind");

  a_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.end_of_file |->
      out_r.verdict == 1'b0 && out_r.records_declared == 32'd0 &&
      out_r.word_kind != crsc_pkg::KIND_STATUS)
    else $error("record word carries status fields");
`endif

endmodule

// ===== hw/rtl/crsc_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc_parse: file parser and integrity state
// Holds the hash, byte position and gathered words of the current file and
// produces at most one result per byte when step is high.
// ----------------------------------------------------------------------------
module crsc_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  logic [31:0]       expected_magic,
  input  logic [31:0]       expected_version,
  output logic              res_valid,
  output crsc_pkg::result_t res
);

  localparam int POS_W = crsc_pkg::POS_W;
  localparam int OFF_W = crsc_pkg::OFF_W;

  logic [63:0]       hash_r, hash_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [63:0]       gather_r, gather_nxt;
  logic              hdr_ok_r, hdr_ok_nxt;
  logic [31:0]       count_r, count_nxt;
  logic [31:0]       x_r, x_nxt;
  logic [31:0]       y_r, y_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [31:0]       rec_cnt_r, rec_cnt_nxt;
  logic [63:0]       trailer_r, trailer_nxt;
  logic [POS_W-1:0]  body_end_r, body_end_nxt;
  logic [POS_W-1:0]  file_end_r, file_end_nxt;

  logic              in_hdr, in_body, in_trl;
  logic              hdr_done, body_done;
  logic [2:0]        hdr_sel;
  logic              off_lt8;
  logic [OFF_W-1:0]  rel;
  logic [3:0]        wsel;
  logic [2:0]        lane;
  logic [63:0]       gather_ins;
  logic [31:0]       hdr_word;
  logic              file_ok;
  logic [2:0]        kind;
  logic [1:0]        comp;

  always_comb begin
    in_hdr  = pos_r < crsc_pkg::HEADER_END;
    in_body = !in_hdr && (pos_r < body_end_r);
    in_trl  = !in_hdr && !in_body && (pos_r < file_end_r);

    hdr_sel  = pos_r[4:2];
    hdr_done = in_hdr && (pos_r[1:0] == 2'd3);

    off_lt8   = off_r < OFF_W'(8);
    rel       = off_r - OFF_W'(8);
    wsel      = rel[5:2];
    body_done = in_body && (off_lt8 ? (off_r == OFF_W'(7)) : (rel[1:0] == 2'd3));

    if (in_hdr) begin
      lane = {1'b0, pos_r[1:0]};
    end else if (off_lt8) begin
      lane = off_r[2:0];
    end else begin
      lane = {1'b0, rel[1:0]};
    end
    gather_ins = crsc_pkg::put_lane(gather_r, lane, data_byte);
    hdr_word   = gather_ins[31:0];

    if (wsel < 4'd3) begin
      kind = crsc_pkg::KIND_POSITION;
      comp = wsel[1:0];
    end else if (wsel < 4'd7) begin
      kind = crsc_pkg::KIND_ROTATION;
      comp = 2'(wsel - 4'd3);
    end else begin
      kind = crsc_pkg::KIND_SCALE;
      comp = 2'(wsel - 4'd7);
    end
    if (off_lt8) begin
      kind = crsc_pkg::KIND_ID;
      comp = 2'd0;
    end

    hash_nxt     = (in_hdr || in_body) ? crsc_pkg::fnv_step(hash_r, data_byte) : hash_r;
    gather_nxt   = gather_r;
    hdr_ok_nxt   = hdr_ok_r;
    count_nxt    = count_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    off_nxt      = off_r;
    rec_cnt_nxt  = rec_cnt_r;
    trailer_nxt  = trailer_r;
    body_end_nxt = body_end_r;
    file_end_nxt = file_end_r;

    if (in_hdr || in_body) begin
      gather_nxt = (hdr_done || body_done) ? 64'd0 : gather_ins;
    end

    if (hdr_done) begin
      case (hdr_sel)
        crsc_pkg::HDR_MAGIC: begin
          if (hdr_word != expected_magic) hdr_ok_nxt = 1'b0;
        end
        crsc_pkg::HDR_VERSION: begin
          if (hdr_word != expected_version) hdr_ok_nxt = 1'b0;
        end
        crsc_pkg::HDR_X: x_nxt = hdr_word;
        crsc_pkg::HDR_Y: y_nxt = hdr_word;
        default: begin
          count_nxt    = hdr_word;
          body_end_nxt = crsc_pkg::body_end_of(hdr_word);
          file_end_nxt = crsc_pkg::body_end_of(hdr_word) + POS_W'(crsc_pkg::TrailerLen);
        end
      endcase
    end

    if (in_body) begin
      if (off_r == crsc_pkg::REC_LAST) begin
        off_nxt     = '0;
        rec_cnt_nxt = rec_cnt_r + 32'd1;
      end else begin
        off_nxt = off_r + OFF_W'(1);
      end
    end

    // Trailer byte lane is the offset past the body, whose low bits are a
    // difference of the low bits alone.
    if (in_trl) begin
      trailer_nxt = crsc_pkg::put_lane(trailer_r, pos_r[2:0] - body_end_r[2:0], data_byte);
    end

    file_ok = hdr_ok_nxt && (pos_r != crsc_pkg::POS_MAX) &&
              (({1'b0, pos_r} + (POS_W+1)'(1)) == {1'b0, file_end_r}) &&
              (trailer_nxt == hash_nxt);

    pos_nxt = (pos_r == crsc_pkg::POS_MAX) ? pos_r : pos_r + POS_W'(1);

    res_valid = final_byte || body_done;
    res       = '0;
    if (final_byte) begin
      res.word_kind        = crsc_pkg::KIND_STATUS;
      res.record_number    = rec_cnt_nxt;
      res.word_value       = hash_nxt;
      res.verdict          = !file_ok;
      res.cell_x           = x_nxt;
      res.cell_y           = y_nxt;
      res.records_declared = count_nxt;
      res.end_of_file      = 1'b1;
    end else begin
      res.word_kind     = kind;
      res.component     = comp;
      res.record_number = rec_cnt_r;
      res.word_value    = gather_ins;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && final_byte)) begin
      hash_r     <= crsc_pkg::HASH_BASIS;
      pos_r      <= '0;
      gather_r   <= '0;
      hdr_ok_r   <= 1'b1;
      count_r    <= '0;
      x_r        <= '0;
      y_r        <= '0;
      off_r      <= '0;
      rec_cnt_r  <= '0;
      trailer_r  <= '0;
      body_end_r <= crsc_pkg::HEADER_END;
      file_end_r <= crsc_pkg::FILE_END_0;
    end else if (step) begin
      hash_r     <= hash_nxt;
      pos_r      <= pos_nxt;
      gather_r   <= gather_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      count_r    <= count_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      off_r      <= off_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
      trailer_r  <= trailer_nxt;
      body_end_r <= body_end_nxt;
      file_end_r <= file_end_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= crsc_pkg::REC_LAST)
    else $error("record offset beyond the record length");

  a_file_end: assert property (@(posedge clk) disable iff (!rst_n)
    file_end_r == body_end_r + POS_W'(crsc_pkg::TrailerLen))
    else $error("file end does not follow body end");

  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    step && final_byte |=> pos_r == '0 && hash_r == crsc_pkg::HASH_BASIS && rec_cnt_r == '0)
    else $error("file state not cleared after the last byte");
`endif

endmodule

// ===== dv/crsc_file_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc_file_checker: result predictor and comparator for the record checker
// Watches the byte, result and register write channels, parses each accepted
// byte like the block does (header checks, record words, FNV-1a-64 trailer)
// and compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module crsc_file_checker (
  input  logic clk,
  input  logic rst_n,
  crsc_byte_if byte_mon,
  crsc_word_if word_mon,
  crsc_cfg_if  cfg_mon,
  output int   fail_count,
  output int   words_pending
);

  localparam logic [63:0] FnvPrime  = 64'h0000_0100_0000_01b3;

  logic [31:0] magic_reg;
  logic [31:0] version_reg;

  logic [63:0] hash_acc;
  logic [39:0] byte_pos;
  logic [63:0] gather;
  logic        header_good;
  logic [31:0] count_hdr;
  logic [31:0] x_hdr;
  logic [31:0] y_hdr;
  logic [5:0]  rec_off;
  logic [31:0] rec_count;
  logic [63:0] trailer;

  crsc_pkg::result_t expected_words[$];
  int      fail_total = 0;

  assign fail_count = fail_total;

  task automatic clear_file();
    hash_acc    = crsc_pkg::HASH_BASIS;
    byte_pos    = '0;
    gather      = '0;
    header_good = 1'b1;
    count_hdr   = '0;
    x_hdr       = '0;
    y_hdr       = '0;
    rec_off     = '0;
    rec_count   = '0;
    trailer     = '0;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fail_total++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    crsc_pkg::result_t want;
    if (expected_words.size() == 0) begin
      fail_total++;
      $display("%0t: unexpected result, expected none, actual kind %0d value %h",
               $time, word_mon.word_kind, word_mon.word_value);
    end else begin
      want = expected_words.pop_front();
      compare_field("word_kind", 64'(want.word_kind), 64'(word_mon.word_kind));
      compare_field("component", 64'(want.component), 64'(word_mon.component));
      compare_field("record_number", 64'(want.record_number),
                    64'(word_mon.record_number));
      compare_field("word_value", want.word_value, word_mon.word_value);
      compare_field("verdict", 64'(want.verdict), 64'(word_mon.verdict));
      compare_field("cell_x", 64'($unsigned(want.cell_x)), 64'($unsigned(word_mon.cell_x)));
      compare_field("cell_y", 64'($unsigned(want.cell_y)), 64'($unsigned(word_mon.cell_y)));
      compare_field("records_declared", 64'(want.records_declared),
                    64'(word_mon.records_declared));
      compare_field("end_of_file", 64'(want.end_of_file), 64'(word_mon.end_of_file));
    end
  endtask

  // Advances the parse by one byte and queues the word it completes, if any.
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    logic [63:0] pos;
    logic [63:0] body_end;
    logic        have_word;
    logic [2:0]  kind;
    logic [1:0]  comp;
    logic [31:0] slot_word;
    int          lane;
    int          wi;
    crsc_pkg::result_t r;
    pos       = 64'(byte_pos);
    body_end  = 64'(crsc_pkg::HeaderLen) + 64'(count_hdr) * 64'(crsc_pkg::RecordLen);
    have_word = 1'b0;
    kind      = crsc_pkg::KIND_ID;
    comp      = 2'd0;
    r         = '0;
    if (pos < 64'(crsc_pkg::HeaderLen)) begin
      lane = int'(pos[1:0]);
      hash_acc = (hash_acc ^ 64'(b)) * FnvPrime;
      gather[8*lane +: 8] = b;
      if (lane == 3) begin
        slot_word = gather[31:0];
        case (pos[4:2])
          crsc_pkg::HDR_MAGIC:   if (slot_word != magic_reg) header_good = 1'b0;
          crsc_pkg::HDR_VERSION: if (slot_word != version_reg) header_good = 1'b0;
          crsc_pkg::HDR_X:       x_hdr = slot_word;
          crsc_pkg::HDR_Y:       y_hdr = slot_word;
          default:               count_hdr = slot_word;
        endcase
        gather = '0;
      end
    end else if (pos < body_end) begin
      hash_acc = (hash_acc ^ 64'(b)) * FnvPrime;
      if (rec_off < 6'd8) begin
        gather[8*rec_off +: 8] = b;
        have_word = (rec_off == 6'd7);
      end else begin
        lane = int'(rec_off - 6'd8) & 3;
        gather[8*lane +: 8] = b;
        if (lane == 3) begin
          // Ten float words follow the id: three position, four rotation, three scale.
          wi = int'(rec_off - 6'd8) >> 2;
          have_word = 1'b1;
          if (wi < 3) begin
            kind = crsc_pkg::KIND_POSITION;
            comp = 2'(wi);
          end else if (wi < 7) begin
            kind = crsc_pkg::KIND_ROTATION;
            comp = 2'(wi - 3);
          end else begin
            kind = crsc_pkg::KIND_SCALE;
            comp = 2'(wi - 7);
          end
        end
      end
      if (have_word) begin
        r.word_kind     = kind;
        r.component     = comp;
        r.record_number = rec_count;
        r.word_value    = gather;
        gather = '0;
      end
      if (rec_off == 6'(crsc_pkg::RecordLen - 1)) begin
        rec_off = '0;
        rec_count++;
      end else begin
        rec_off++;
      end
    end else if (pos < body_end + 64'(crsc_pkg::TrailerLen)) begin
      lane = int'(pos - body_end);
      trailer[8*lane +: 8] = b;
    end

    if (fin) begin
      // The status replaces any word completed by the last byte.
      r = '0;
      r.word_kind        = crsc_pkg::KIND_STATUS;
      r.record_number    = rec_count;
      r.word_value       = hash_acc;
      r.verdict          = !(header_good && byte_pos != crsc_pkg::POS_MAX &&
                             pos + 64'd1 == body_end + 64'(crsc_pkg::TrailerLen) &&
                             trailer == hash_acc);
      r.cell_x           = x_hdr;
      r.cell_y           = y_hdr;
      r.records_declared = count_hdr;
      r.end_of_file      = 1'b1;
      expected_words.insert(expected_words.size(), r);
      clear_file();
    end else begin
      if (byte_pos != crsc_pkg::POS_MAX) byte_pos++;
      if (have_word) expected_words.insert(expected_words.size(), r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      magic_reg   = '0;
      version_reg = '0;
      clear_file();
      expected_words.delete();
    end else begin
      if (word_mon.valid && word_mon.ready) check_word();
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == crsc_pkg::CFG_MAGIC) magic_reg = cfg_mon.write_data;
        else if (cfg_mon.reg_index == crsc_pkg::CFG_VERSION) version_reg = cfg_mon.write_data;
      end
      if (byte_mon.valid && byte_mon.ready) parse_byte(byte_mon.data_byte, byte_mon.final_byte);
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level for the cell record stream checker
// Builds record files (good ones and files with bad magic, version, trailer,
// length or count, plus raw noise), streams them byte by byte under varying
// sender and receiver idling, reprograms the header registers between files
// and leaves the comparison to the file checker.
// ----------------------------------------------------------------------------
module tb;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_MAGIC,
    SHAPE_BAD_VERSION,
    SHAPE_BAD_TRAILER,
    SHAPE_SHORT,
    SHAPE_WORD_CUT,
    SHAPE_OVERRUN,
    SHAPE_WRONG_COUNT,
    SHAPE_NOISE
  } file_shape_t;

  localparam int RandomBytes = 1600;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;
  int holds_served;
  int hold_left;
  int bytes_sent         = 0;
  int fail_count;
  int words_pending;

  logic [31:0] magic_now   = '0;
  logic [31:0] version_now = '0;
  logic [7:0]  file_bytes[$];

  crsc_byte_if in_if ();
  crsc_word_if out_if ();
  crsc_cfg_if  cfg_if ();

  cell_record_stream_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  crsc_file_checker file_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_mon      (in_if),
    .word_mon      (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #2 clk = ~clk;

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      holds_served <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_if.ready <= 1'b0;
      holds_served <= hold_requests;
      hold_left    <= LongHold;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic void set_phase(input int p);
    case (p % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
      default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_file(input file_shape_t shape, input int records);
    logic [63:0] h;
    logic [31:0] declared;
    int          cut;
    cut = 0;
    file_bytes.delete();
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(40, 1)) add_byte(8'($urandom));
      return;
    end
    declared = records;
    if (shape == SHAPE_WRONG_COUNT)
      declared = $urandom_range(1) ? 32'hffff_ffff : records + 1;
    push_word(shape == SHAPE_BAD_MAGIC ? magic_now ^ (32'd1 << $urandom_range(31)) : magic_now);
    push_word(shape == SHAPE_BAD_VERSION ? version_now ^ (32'd1 << $urandom_range(31))
                                         : version_now);
    push_word(pick_coord());
    push_word(pick_coord());
    push_word(declared);
    repeat (records * crsc_pkg::RecordLen) add_byte(8'($urandom));
    h = crsc_pkg::HASH_BASIS;
    foreach (file_bytes[i]) h = (h ^ 64'(file_bytes[i])) * 64'h0000_0100_0000_01b3;
    if (shape == SHAPE_BAD_TRAILER) h ^= 64'd1 << $urandom_range(63);
    for (int i = 0; i < 8; i++) add_byte(h[8*i +: 8]);
    case (shape)
      SHAPE_SHORT: cut = $urandom_range(file_bytes.size() - 1, 1);
      // End the file exactly where a record word completes.
      SHAPE_WORD_CUT: cut = crsc_pkg::HeaderLen +
                            crsc_pkg::RecordLen * int'($urandom_range(records - 1)) +
                            8 + 4 * int'($urandom_range(10));
      SHAPE_OVERRUN: repeat ($urandom_range(6, 1)) add_byte(8'($urandom));
      default: cut = 0;
    endcase
    if (cut != 0) while (file_bytes.size() > cut) void'(file_bytes.pop_back());
  endtask

  // Leaves valid high after the request is taken, so back-to-back bytes flow.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.final_byte <= fin;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic reprogram(input logic [31:0] m, input logic [31:0] v);
    drain();
    cfg_if.valid      <= 1'b1;
    cfg_if.reg_index  <= crsc_pkg::CFG_MAGIC;
    cfg_if.write_data <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.reg_index  <= crsc_pkg::CFG_VERSION;
    cfg_if.write_data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    magic_now   = m;
    version_now = v;
  endtask

  initial begin
    file_shape_t shape;
    int          records;
    int          roll;
    int          file_idx;
    int          setting;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.final_byte  <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.reg_index  <= crsc_pkg::CFG_MAGIC;
    cfg_if.write_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a one-byte file against the reset registers, then a good empty
    // file and a file cut where a record word completes under extreme registers.
    file_bytes.delete();
    add_byte(8'hff);
    send_file();
    reprogram(32'hffff_ffff, 32'h0000_0000);
    build_file(SHAPE_GOOD, 0);
    send_file();
    build_file(SHAPE_WORD_CUT, 1);
    send_file();

    file_idx = 0;
    setting  = 0;
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      if (file_idx % 6 == 0) begin
        case (setting % 4)
          0:       reprogram(32'h0000_0000, 32'hffff_ffff);
          1:       reprogram(32'hffff_ffff, 32'hffff_ffff);
          default: reprogram($urandom, $urandom);
        endcase
        setting++;
      end
      set_phase(file_idx);
      roll = $urandom_range(9);
      records = (roll < 2) ? 0 : (roll < 7) ? 1 : (roll < 9) ? 2 : 3;
      roll = $urandom_range(99);
      if (roll < 50)      shape = SHAPE_GOOD;
      else if (roll < 56) shape = SHAPE_BAD_MAGIC;
      else if (roll < 62) shape = SHAPE_BAD_VERSION;
      else if (roll < 68) shape = SHAPE_BAD_TRAILER;
      else if (roll < 76) shape = SHAPE_SHORT;
      else if (roll < 84) shape = SHAPE_WORD_CUT;
      else if (roll < 90) shape = SHAPE_OVERRUN;
      else if (roll < 95) shape = SHAPE_WRONG_COUNT;
      else                shape = SHAPE_NOISE;
      if (shape == SHAPE_WORD_CUT && records == 0) records = 1;
      // Now and then the result side holds off while a long file keeps coming,
      // so the block backs up and stops taking requests.
      if (file_idx % 16 == 8) begin
        shape   = SHAPE_GOOD;
        records = 2;
        set_phase(0);
        hold_requests <= hold_requests + 1;
      end
      build_file(shape, records);
      send_file();
      file_idx++;
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
